// ===== rtl/core/ssgh_pkg.sv =====
// Package for the gap-halving shell sorter: widths, microcode step codes,
// control word and status types, and the microcode table.
// Depends on nothing; used by every file in rtl/core.
package ssgh_pkg;

   // Field widths fixed by the interface
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 16;
   localparam int MOVE_W       = 18;
   localparam int SET_SIZE_DEF = 16;

   // Microcode step addresses
   typedef enum logic [3:0] {
      S_IDLE       = 4'd0,
      S_INIT       = 4'd1,
      S_GAP        = 4'd2,
      S_PASS_START = 4'd3,
      S_READ       = 4'd4,
      S_CMP        = 4'd5,
      S_SWAP       = 4'd6,
      S_PASS_END   = 4'd7,
      S_PASS_BACK  = 4'd8,
      S_EMIT_READ  = 4'd9,
      S_EMIT_OUT   = 4'd10,
      S_EMIT_DONE  = 4'd11
   } step_type;

   // Jump conditions; false falls through to the next step
   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_NOT_SET_DONE,
      C_GAP_DONE,
      C_MORE_PAIRS,
      C_SWAPPED,
      C_NOT_LAST
   } cond_type;

   // One microcode word
   typedef struct packed {
      cond_type jump_cond;
      step_type target;
      logic     gap_load;
      logic     gap_halve;
      logic     idx_clear;
      logic     idx_inc;
      logic     rd_en;
      logic     cmp_en;
      logic     swap_en;
      logic     pass_clear;
      logic     emit;
      logic     count_clear;
   } ctrl_word_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic set_done;
      logic gap_done;
      logic more_pairs;
      logic swapped;
      logic last_idx;
   } dp_status_type;

   // Microcode table
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '{jump_cond: C_NONE, target: S_IDLE, default: 1'b0};
      case (step)
         S_IDLE: begin
            w.jump_cond = C_NOT_SET_DONE;
            w.target    = S_IDLE;
         end
         S_INIT: begin
            w.gap_load    = 1'b1;
            w.count_clear = 1'b1;
         end
         S_GAP: begin
            w.gap_halve = 1'b1;
            w.idx_clear = 1'b1;
            w.jump_cond = C_GAP_DONE;
            w.target    = S_EMIT_READ;
         end
         S_PASS_START: begin
            w.pass_clear = 1'b1;
            w.idx_clear  = 1'b1;
         end
         S_READ: begin
            w.rd_en = 1'b1;
         end
         S_CMP: begin
            w.cmp_en = 1'b1;
         end
         S_SWAP: begin
            w.swap_en   = 1'b1;
            w.idx_inc   = 1'b1;
            w.jump_cond = C_MORE_PAIRS;
            w.target    = S_READ;
         end
         S_PASS_END: begin
            w.jump_cond = C_SWAPPED;
            w.target    = S_PASS_START;
         end
         S_PASS_BACK: begin
            w.jump_cond = C_ALWAYS;
            w.target    = S_GAP;
         end
         S_EMIT_READ: begin
            w.rd_en = 1'b1;
         end
         S_EMIT_OUT: begin
            w.emit      = 1'b1;
            w.idx_inc   = 1'b1;
            w.jump_cond = C_NOT_LAST;
            w.target    = S_EMIT_READ;
         end
         S_EMIT_DONE: begin
            w.jump_cond = C_ALWAYS;
            w.target    = S_IDLE;
         end
         default: begin
            w.jump_cond = C_ALWAYS;
            w.target    = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/shell_sorter_gap_halving.sv =====
// Top level of the gap-halving shell sorter: order register, sequencer
// and datapath. Depends on ssgh_pkg, ssgh_seq and ssgh_dp.
//
//  channel   ports                         transfer
//  request   start, busy, req_*            start high and busy low
//  result    rsp_strobe, rsp_*             one cycle per result, no stall
//  csr       csr_valid, csr_ready, csr_*   csr_valid and csr_ready high
//
// Loading accepts one request per cycle while busy is low; requests can
// follow back to back. After the last request of a set busy stays high
// through the sort, each gap stage and each pass of compares, and then
// through the output of the results.
// Reset clears the step counter, load count and sort counters, not memory.
// Results cannot be stalled; the order register is written only while idle.
module shell_sorter_gap_halving #(
   parameter int SET_SIZE = ssgh_pkg::SET_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [ssgh_pkg::DATA_W-1:0] req_element_value,
   output logic                               rsp_strobe,
   output logic signed [ssgh_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                               rsp_last_of_set,
   output logic [ssgh_pkg::COUNT_W-1:0]       rsp_comparison_count,
   output logic [ssgh_pkg::COUNT_W-1:0]       rsp_swap_count,
   output logic [ssgh_pkg::MOVE_W-1:0]        rsp_movement_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_sort_descending
);

   ssgh_pkg::ctrl_word_type ctrl;
   ssgh_pkg::dp_status_type status;
   logic                    descending_ff;
   logic                    accept;

   assign accept    = start && !busy;
   assign csr_ready = !busy;

   // Sort order register
   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         descending_ff <= csr_sort_descending;
      end
   end

   ssgh_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   ssgh_dp #(
      .SET_SIZE (SET_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .load_en    (accept),
      .load_value (req_element_value),
      .descending (descending_ff),
      .status     (status),
      .out_value  (rsp_sorted_value),
      .comp_count (rsp_comparison_count),
      .swap_count (rsp_swap_count),
      .move_count (rsp_movement_count)
   );

   // Result strobe and end-of-set mark
   assign rsp_strobe      = ctrl.emit;
   assign rsp_last_of_set = status.last_idx;

   // Checks
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_of_set) |=> !rsp_strobe)
      else $error("result after end of set");

   a_swaps_le_comps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_swap_count <= rsp_comparison_count))
      else $error("more swaps than comparisons");

   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results in adjacent cycles");

endmodule

// ===== rtl/core/ssgh_seq.sv =====
// Microcode sequencer: step counter, table lookup and conditional jumps.
// Depends on ssgh_pkg.
module ssgh_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  ssgh_pkg::dp_status_type status,
   output ssgh_pkg::ctrl_word_type ctrl,
   output logic                   busy
);

   ssgh_pkg::step_type upc_ff;
   ssgh_pkg::step_type upc_in;
   logic               take_jump;

   // Control word for the current step
   assign ctrl = ssgh_pkg::ucode_rom(upc_ff);
   assign busy = (upc_ff != ssgh_pkg::S_IDLE);

   // Jump condition select and next step
   always_comb begin
      case (ctrl.jump_cond)
         ssgh_pkg::C_NONE:         take_jump = 1'b0;
         ssgh_pkg::C_ALWAYS:       take_jump = 1'b1;
         ssgh_pkg::C_NOT_SET_DONE: take_jump = !status.set_done;
         ssgh_pkg::C_GAP_DONE:     take_jump = status.gap_done;
         ssgh_pkg::C_MORE_PAIRS:   take_jump = status.more_pairs;
         ssgh_pkg::C_SWAPPED:      take_jump = status.swapped;
         ssgh_pkg::C_NOT_LAST:     take_jump = !status.last_idx;
         default:                  take_jump = 1'b1;
      endcase
      if (take_jump) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = ssgh_pkg::step_type'(upc_ff + 4'd1);
      end
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ssgh_pkg::S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== rtl/core/ssgh_dp.sv =====
// Sorter datapath: element memory with two registered read ports, gap and
// index registers, compare-exchange logic and saturating counters.
// Depends on ssgh_pkg; driven by ssgh_seq control words.
module ssgh_dp #(
   parameter int SET_SIZE = ssgh_pkg::SET_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ssgh_pkg::ctrl_word_type        ctrl,
   input  logic                          load_en,
   input  logic signed [ssgh_pkg::DATA_W-1:0] load_value,
   input  logic                          descending,
   output ssgh_pkg::dp_status_type        status,
   output logic signed [ssgh_pkg::DATA_W-1:0] out_value,
   output logic [ssgh_pkg::COUNT_W-1:0]  comp_count,
   output logic [ssgh_pkg::COUNT_W-1:0]  swap_count,
   output logic [ssgh_pkg::MOVE_W-1:0]   move_count
);

   localparam int IDX_W = $clog2(SET_SIZE);
   localparam int GAP_W = $clog2(SET_SIZE + 1);
   localparam int SUM_W = $clog2(2 * SET_SIZE + 2);
   localparam logic [ssgh_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   logic signed [ssgh_pkg::DATA_W-1:0] store_mem [SET_SIZE];
   logic signed [ssgh_pkg::DATA_W-1:0] rd_a_ff;
   logic signed [ssgh_pkg::DATA_W-1:0] rd_b_ff;

   logic [IDX_W-1:0]           load_cnt_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic [GAP_W-1:0]           gap_ff;
   logic                       swapped_ff;
   logic                       ooo_ff;
   logic [ssgh_pkg::COUNT_W-1:0] comp_ff;
   logic [ssgh_pkg::COUNT_W-1:0] swap_ff;

   logic                       load_last;
   logic [SUM_W-1:0]           sum_b;
   logic [SUM_W-1:0]           sum_next;
   logic [IDX_W-1:0]           addr_b;
   logic                       out_of_order;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic signed [ssgh_pkg::DATA_W-1:0] wr_data;

   // Address arithmetic
   assign load_last = (load_cnt_ff == IDX_W'(SET_SIZE - 1));
   assign sum_b     = SUM_W'(idx_ff) + SUM_W'(gap_ff);
   assign sum_next  = sum_b + SUM_W'(1);
   assign addr_b    = sum_b[IDX_W-1:0];

   // Pair is out of order for the chosen direction
   assign out_of_order = descending ? (rd_b_ff > rd_a_ff) : (rd_a_ff > rd_b_ff);

   // Write port: load, then the two halves of an exchange
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = load_cnt_ff;
      wr_data = load_value;
      if (load_en) begin
         wr_en = 1'b1;
      end else if (ctrl.cmp_en && out_of_order) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = rd_b_ff;
      end else if (ctrl.swap_en && ooo_ff) begin
         wr_en   = 1'b1;
         wr_addr = addr_b;
         wr_data = rd_a_ff;
      end
   end

   // Element memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_a_ff <= store_mem[idx_ff];
         rd_b_ff <= store_mem[addr_b];
      end
   end

   // Control registers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         idx_ff      <= '0;
         gap_ff      <= '0;
         swapped_ff  <= 1'b0;
         ooo_ff      <= 1'b0;
         comp_ff     <= '0;
         swap_ff     <= '0;
      end else begin
         if (load_en) begin
            load_cnt_ff <= load_last ? '0 : load_cnt_ff + IDX_W'(1);
         end
         if (ctrl.idx_clear) begin
            idx_ff <= '0;
         end else if (ctrl.idx_inc) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (ctrl.gap_load) begin
            gap_ff <= GAP_W'(SET_SIZE);
         end else if (ctrl.gap_halve && !status.gap_done) begin
            gap_ff <= gap_ff >> 1;
         end
         if (ctrl.pass_clear) begin
            swapped_ff <= 1'b0;
         end else if (ctrl.swap_en && ooo_ff) begin
            swapped_ff <= 1'b1;
         end
         if (ctrl.cmp_en) begin
            ooo_ff <= out_of_order;
         end
         if (ctrl.count_clear) begin
            comp_ff <= '0;
            swap_ff <= '0;
         end else begin
            if (ctrl.cmp_en && comp_ff != COUNT_MAX) begin
               comp_ff <= comp_ff + ssgh_pkg::COUNT_W'(1);
            end
            if (ctrl.swap_en && ooo_ff && swap_ff != COUNT_MAX) begin
               swap_ff <= swap_ff + ssgh_pkg::COUNT_W'(1);
            end
         end
      end
   end

   // Status to the sequencer
   assign status.set_done   = load_en && load_last;
   assign status.gap_done   = (gap_ff <= GAP_W'(1));
   assign status.more_pairs = (sum_next < SUM_W'(SET_SIZE));
   assign status.swapped    = swapped_ff;
   assign status.last_idx   = (idx_ff == IDX_W'(SET_SIZE - 1));

   // Result fields; moves are three per exchange
   assign out_value  = rd_a_ff;
   assign comp_count = comp_ff;
   assign swap_count = swap_ff;
   assign move_count = {1'b0, swap_ff, 1'b0} + ssgh_pkg::MOVE_W'(swap_ff);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for shell_sorter_gap_halving: a directed table, then random sets,
// each sorted set checked against a local gap-halving predictor.
// Depends on ssgh_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb;

   localparam int SET_N       = ssgh_pkg::SET_SIZE_DEF;
   localparam int ITEMS       = 420;
   localparam int SETTLE_CYC  = 8;
   localparam int DRAIN_CYC   = 40;
   localparam int CYCLE_LIMIT = 500000;
   localparam int REPORT_MAX  = 10;
   localparam int DIR_N       = 24;
   localparam logic [ssgh_pkg::COUNT_W-1:0] COUNT_SAT = '1;

   // Random fill patterns for one set
   typedef enum logic [2:0] {
      FILL_RANDOM,
      FILL_NARROW,
      FILL_RAMP_UP,
      FILL_RAMP_DOWN,
      FILL_EXTREMES
   } fill_type;

   // One expected result
   typedef struct packed {
      logic signed [ssgh_pkg::DATA_W-1:0] value;
      logic                               is_last;
      logic [ssgh_pkg::COUNT_W-1:0]       cmp_cnt;
      logic [ssgh_pkg::COUNT_W-1:0]       swp_cnt;
      logic [ssgh_pkg::MOVE_W-1:0]        mov_cnt;
   } sorted_rsp_type;

   // One directed row: optional order write, then the request
   typedef struct packed {
      logic                               order_wr;
      logic                               order_desc;
      logic signed [ssgh_pkg::DATA_W-1:0] value;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      // first set: extremes, order flipped to descending mid-load
      '{1'b0, 1'b0, 32'sh7FFF_FFFF}, '{1'b0, 1'b0, 32'sh8000_0000},
      '{1'b0, 1'b0, 32'sh0000_0000}, '{1'b0, 1'b0, 32'shFFFF_FFFF},
      '{1'b0, 1'b0, 32'sh0000_0001}, '{1'b0, 1'b0, 32'sh5555_5555},
      '{1'b0, 1'b0, 32'shAAAA_AAAA}, '{1'b0, 1'b0, 32'sh7FFF_FFFE},
      '{1'b1, 1'b1, 32'sh8000_0001}, '{1'b0, 1'b0, 32'sh7FFF_FFFF},
      '{1'b0, 1'b0, 32'sh8000_0000}, '{1'b0, 1'b0, 32'sh0000_0000},
      '{1'b0, 1'b0, 32'sh0000_FFFF}, '{1'b0, 1'b0, 32'shFFFF_0000},
      '{1'b0, 1'b0, 32'sh1234_5678}, '{1'b0, 1'b0, 32'shEDCB_A988},
      // second set starts ascending; random part completes it
      '{1'b1, 1'b0, 32'sh0000_0010}, '{1'b0, 1'b0, 32'shFFFF_FFF0},
      '{1'b0, 1'b0, 32'sh0000_0010}, '{1'b0, 1'b0, 32'sh0000_0000},
      '{1'b0, 1'b0, 32'sh8000_0000}, '{1'b0, 1'b0, 32'sh7FFF_FFFF},
      '{1'b0, 1'b0, 32'shFFFF_FFFE}, '{1'b0, 1'b0, 32'sh0000_0002}
   };

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic signed [ssgh_pkg::DATA_W-1:0] req_element_value;
   logic                               rsp_strobe;
   logic signed [ssgh_pkg::DATA_W-1:0] rsp_sorted_value;
   logic                               rsp_last_of_set;
   logic [ssgh_pkg::COUNT_W-1:0]       rsp_comparison_count;
   logic [ssgh_pkg::COUNT_W-1:0]       rsp_swap_count;
   logic [ssgh_pkg::MOVE_W-1:0]        rsp_movement_count;
   logic                               csr_valid;
   logic                               csr_ready;
   logic                               csr_sort_descending;

   // Predictor state
   logic signed [ssgh_pkg::DATA_W-1:0] set_buf [SET_N];
   int                                 loaded_cnt = 0;
   logic                               order_desc = 1'b0;
   sorted_rsp_type                     sorted_q [$];
   int                                 mismatch_cnt = 0;
   int                                 cycle_cnt = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   shell_sorter_gap_halving #(.SET_SIZE(SET_N)) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_element_value    (req_element_value),
      .rsp_strobe           (rsp_strobe),
      .rsp_sorted_value     (rsp_sorted_value),
      .rsp_last_of_set      (rsp_last_of_set),
      .rsp_comparison_count (rsp_comparison_count),
      .rsp_swap_count       (rsp_swap_count),
      .rsp_movement_count   (rsp_movement_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_sort_descending  (csr_sort_descending)
   );

   // Gap-halving sort of the loaded set; queues one result per element
   function automatic void predict_sorted_set();
      logic signed [ssgh_pkg::DATA_W-1:0] x;
      logic signed [ssgh_pkg::DATA_W-1:0] y;
      logic [ssgh_pkg::COUNT_W-1:0]       cmps;
      logic [ssgh_pkg::COUNT_W-1:0]       swps;
      logic                               swapped;
      int                                 gap;
      sorted_rsp_type                     r;
      cmps = '0;
      swps = '0;
      gap  = SET_N;
      while (gap > 1) begin
         gap = gap / 2;
         swapped = 1'b1;
         while (swapped) begin
            swapped = 1'b0;
            for (int i = 0; i + gap < SET_N; i++) begin
               x = set_buf[i];
               y = set_buf[i + gap];
               if (cmps != COUNT_SAT) cmps++;
               if (order_desc ? (y > x) : (x > y)) begin
                  set_buf[i]       = y;
                  set_buf[i + gap] = x;
                  if (swps != COUNT_SAT) swps++;
                  swapped = 1'b1;
               end
            end
         end
      end
      for (int k = 0; k < SET_N; k++) begin
         r.value   = set_buf[k];
         r.is_last = (k == SET_N - 1);
         r.cmp_cnt = cmps;
         r.swp_cnt = swps;
         r.mov_cnt = ssgh_pkg::MOVE_W'(swps * 3);
         sorted_q.push_back(r);
      end
   endfunction

   task automatic note_mismatch(input string fld, input longint want, input longint got);
      if (mismatch_cnt < REPORT_MAX)
         $display("mismatch %s: expected %0d, got %0d", fld, want, got);
      mismatch_cnt++;
   endtask

   // Track accepted requests, order writes and results at each edge
   always @(posedge clock) begin
      sorted_rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) order_desc = csr_sort_descending;
         if (start && !busy) begin
            set_buf[loaded_cnt] = req_element_value;
            loaded_cnt++;
            if (loaded_cnt == SET_N) begin
               loaded_cnt = 0;
               predict_sorted_set();
            end
         end
         if (rsp_strobe) begin
            if (sorted_q.size() == 0) begin
               note_mismatch("unexpected result, value", 0, rsp_sorted_value);
            end else begin
               want = sorted_q.pop_front();
               if (rsp_sorted_value !== want.value)
                  note_mismatch("sorted_value", want.value, rsp_sorted_value);
               if (rsp_last_of_set !== want.is_last)
                  note_mismatch("last_of_set", want.is_last, rsp_last_of_set);
               if (rsp_comparison_count !== want.cmp_cnt)
                  note_mismatch("comparison_count", want.cmp_cnt, rsp_comparison_count);
               if (rsp_swap_count !== want.swp_cnt)
                  note_mismatch("swap_count", want.swp_cnt, rsp_swap_count);
               if (rsp_movement_count !== want.mov_cnt)
                  note_mismatch("movement_count", want.mov_cnt, rsp_movement_count);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Hold off requests until every queued result is out and the sequencer is back idle
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (sorted_q.size() != 0 || busy);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_order(input logic desc);
      wait_drained();
      csr_valid           <= 1'b1;
      csr_sort_descending <= desc;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Present one request and hold it until accepted; start stays high afterwards
   task automatic send_element(input logic signed [ssgh_pkg::DATA_W-1:0] v);
      start             <= 1'b1;
      req_element_value <= v;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int                                 sent;
      int                                 pos;
      int                                 burst_left;
      int                                 mid_wr;
      fill_type                           mode;
      logic signed [ssgh_pkg::DATA_W-1:0] base;
      logic signed [ssgh_pkg::DATA_W-1:0] stride;
      logic signed [ssgh_pkg::DATA_W-1:0] v;

      reset               = 1'b1;
      start               = 1'b0;
      req_element_value   = '0;
      csr_valid           = 1'b0;
      csr_sort_descending = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_order(1'b0);

      // Directed table
      for (int r = 0; r < DIR_N; r++) begin
         if (DIR_ROWS[r].order_wr) write_order(DIR_ROWS[r].order_desc);
         send_element(DIR_ROWS[r].value);
      end

      // Random sets in bursts, whole sets to the end
      sent       = DIR_N;
      burst_left = 0;
      mid_wr     = 0;
      mode       = FILL_RANDOM;
      base       = '0;
      stride     = 1;
      while (sent < ITEMS || sent % SET_N != 0) begin
         pos = sent % SET_N;
         if (pos == 0) begin
            mode   = fill_type'($urandom_range(0, 4));
            base   = $urandom;
            stride = $urandom_range(1, 4096);
            if ($urandom_range(0, 3) == 0) write_order(1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 7) == 0) wait_drained();
            mid_wr = ($urandom_range(0, 7) == 0) ? $urandom_range(1, SET_N - 1) : 0;
         end
         // order change while the set is still loading
         if (mid_wr != 0 && pos == mid_wr) write_order(1'($urandom_range(0, 1)));
         if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         case (mode)
            FILL_NARROW:    v = $signed($urandom_range(0, 6)) - 3;
            FILL_RAMP_UP:   v = base + pos * stride;
            FILL_RAMP_DOWN: v = base - pos * stride;
            FILL_EXTREMES: begin
               case ($urandom_range(0, 3))
                  0:       v = 32'sh8000_0000;
                  1:       v = 32'sh7FFF_FFFF;
                  2:       v = '0;
                  default: v = '1;
               endcase
            end
            default:        v = $urandom;
         endcase
         send_element(v);
         sent++;
      end
      start <= 1'b0;

      do @(posedge clock); while (sorted_q.size() != 0 || busy);
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatch_cnt == 0 && sorted_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
